@@ src/bpft_pkg.sv @@
// ----------------------------------------------------------------------------
// bpft_pkg
// shared constants, codes and controller/datapath handshake types of the
// buffer pool frame table
// ----------------------------------------------------------------------------
package bpft_pkg;

   // field widths
   localparam int PAGE_BITS   = 20;
   localparam int CMD_W       = 3;
   localparam int STATUS_W    = 2;
   localparam int FIDX_OUT_W  = 4;
   localparam int CFG_W       = 5;
   localparam int PIN_W       = 8;

   // pool size default and flush limit
   localparam int FRAMES_DEF  = 16;
   localparam int MAX_OUT     = 16;
   localparam int CNT_W       = $clog2(MAX_OUT);

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

   // command codes
   localparam logic [CMD_W-1:0] CMD_PIN   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_UNPIN = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DIRTY = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FORCE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FLUSH = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic exec;
      logic flush_step;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic is_flush;
      logic flush_last;
   } sts_type;

endpackage

@@ src/bpft_ctrl.sv @@
// ----------------------------------------------------------------------------
// bpft_ctrl
// command sequencer: accepts a command, runs an execute step or a run of
// flush steps, then returns to idle
// ----------------------------------------------------------------------------
module bpft_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  bpft_pkg::sts_type sts,
   output bpft_pkg::ctl_type ctl,
   output logic              busy
);
   import bpft_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_RUN
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (sts.is_flush) begin
               ctl.flush_step = 1'b1;
               if (sts.flush_last) begin
                  state_in = S_IDLE;
               end
            end else begin
               ctl.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in == S_RUN);
      end
   end

   assign busy = busy_ff;

endmodule

@@ src/bpft_datapath.sv @@
// ----------------------------------------------------------------------------
// bpft_datapath
// frame table registers, parallel page match and victim search, flush
// selection and the result register
// ----------------------------------------------------------------------------
module bpft_datapath #(
   parameter int FRAMES = bpft_pkg::FRAMES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  bpft_pkg::ctl_type                ctl,
   output bpft_pkg::sts_type                sts,
   input  logic [bpft_pkg::CMD_W-1:0]       req_command,
   input  logic [bpft_pkg::PAGE_BITS-1:0]   req_page_number,
   input  logic                             csr_we,
   input  logic [bpft_pkg::CFG_W-1:0]       csr_data,
   output logic                             rsp_strobe,
   output logic [bpft_pkg::STATUS_W-1:0]    rsp_status,
   output logic [bpft_pkg::FIDX_OUT_W-1:0]  rsp_frame_index,
   output logic                             rsp_read_request,
   output logic                             rsp_write_request,
   output logic [bpft_pkg::PAGE_BITS-1:0]   rsp_write_page,
   output logic                             rsp_last
);
   import bpft_pkg::*;

   localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

   // latched command
   logic [CMD_W-1:0]     cmd_ff;
   logic [PAGE_BITS-1:0] page_ff;
   logic [CFG_W-1:0]     cfg_ff;
   logic [CNT_W-1:0]     flush_cnt_ff;

   // frame table
   logic                 valid_ff [FRAMES];
   logic                 dirty_ff [FRAMES];
   logic [PIN_W-1:0]     pins_ff  [FRAMES];
   logic [PAGE_BITS-1:0] tpage_ff [FRAMES];

   // match vectors
   logic [FRAMES-1:0] in_range, hit_vec, free_vec, elig_vec, elig_low;
   logic              hit_any, free_any, elig_any, elig_rest;
   logic [FIDX_W-1:0] hit_idx, free_idx, elig_idx;

   // table update
   logic              tbl_we, page_we;
   logic [FIDX_W-1:0] tbl_idx;
   logic              entry_valid_in, entry_dirty_in;
   logic [PIN_W-1:0]  entry_pins_in;

   // result
   logic [STATUS_W-1:0]  status_in;
   logic [FIDX_W-1:0]    fidx_in;
   logic                 rd_in, wr_in, last_in, strobe_in;
   logic [PAGE_BITS-1:0] wpage_in;

   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [FIDX_OUT_W-1:0] rsp_fidx_ff;
   logic                  rsp_rd_ff, rsp_wr_ff, rsp_last_ff, rsp_strobe_ff;
   logic [PAGE_BITS-1:0]  rsp_wpage_ff;

   logic flush_limit;

   always_comb begin
      for (int i = 0; i < FRAMES; i++) begin
         in_range[i] = (int'(cfg_ff) > i);
         hit_vec[i]  = in_range[i] && valid_ff[i] && (tpage_ff[i] == page_ff);
         free_vec[i] = in_range[i] && (pins_ff[i] == '0);
         elig_vec[i] = in_range[i] && valid_ff[i] && dirty_ff[i] && (pins_ff[i] == '0);
      end
   end

   // lowest set index of each vector
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      elig_idx = '0;
      for (int i = FRAMES - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_idx = FIDX_W'(i);
         end
         if (free_vec[i]) begin
            free_idx = FIDX_W'(i);
         end
         if (elig_vec[i]) begin
            elig_idx = FIDX_W'(i);
         end
      end
   end

   assign hit_any   = |hit_vec;
   assign free_any  = |free_vec;
   assign elig_any  = |elig_vec;
   assign elig_low  = elig_vec & (~elig_vec + FRAMES'(1));
   assign elig_rest = |(elig_vec & ~elig_low);

   assign flush_limit    = (flush_cnt_ff == CNT_W'(MAX_OUT - 1));
   assign sts.is_flush   = (cmd_ff == CMD_FLUSH);
   assign sts.flush_last = !elig_any || !elig_rest || flush_limit;

   always_comb begin
      tbl_we         = 1'b0;
      page_we        = 1'b0;
      tbl_idx        = '0;
      entry_valid_in = 1'b0;
      entry_dirty_in = 1'b0;
      entry_pins_in  = '0;
      status_in      = ST_OK;
      fidx_in        = '0;
      rd_in          = 1'b0;
      wr_in          = 1'b0;
      wpage_in       = '0;
      last_in        = 1'b1;
      strobe_in      = ctl.exec || ctl.flush_step;
      if (ctl.exec) begin
         case (cmd_ff)
            CMD_PIN: begin
               if (hit_any) begin
                  // already resident: count one more pin, saturating
                  tbl_we         = 1'b1;
                  tbl_idx        = hit_idx;
                  entry_valid_in = valid_ff[hit_idx];
                  entry_dirty_in = dirty_ff[hit_idx];
                  entry_pins_in  = (pins_ff[hit_idx] == '1) ? pins_ff[hit_idx]
                                                           : pins_ff[hit_idx] + PIN_W'(1);
                  fidx_in        = hit_idx;
               end else if (free_any) begin
                  // load into lowest unpinned frame, write back a dirty victim
                  tbl_we         = 1'b1;
                  page_we        = 1'b1;
                  tbl_idx        = free_idx;
                  entry_valid_in = 1'b1;
                  entry_dirty_in = 1'b0;
                  entry_pins_in  = PIN_W'(1);
                  fidx_in        = free_idx;
                  rd_in          = 1'b1;
                  wr_in          = valid_ff[free_idx] && dirty_ff[free_idx];
                  wpage_in       = wr_in ? tpage_ff[free_idx] : '0;
               end else begin
                  status_in = ST_FULL;
               end
            end
            CMD_UNPIN, CMD_DIRTY, CMD_FORCE: begin
               if (!hit_any) begin
                  status_in = ST_NOT_FOUND;
               end else begin
                  tbl_we         = 1'b1;
                  tbl_idx        = hit_idx;
                  entry_valid_in = valid_ff[hit_idx];
                  entry_dirty_in = dirty_ff[hit_idx];
                  entry_pins_in  = pins_ff[hit_idx];
                  fidx_in        = hit_idx;
                  if (cmd_ff == CMD_UNPIN) begin
                     if (pins_ff[hit_idx] != '0) begin
                        entry_pins_in = pins_ff[hit_idx] - PIN_W'(1);
                     end
                  end else if (cmd_ff == CMD_DIRTY) begin
                     entry_dirty_in = 1'b1;
                  end else begin
                     entry_dirty_in = 1'b0;
                     wr_in          = 1'b1;
                     wpage_in       = tpage_ff[hit_idx];
                  end
               end
            end
            default: begin
            end
         endcase
      end else if (ctl.flush_step) begin
         if (elig_any) begin
            tbl_we         = 1'b1;
            tbl_idx        = elig_idx;
            entry_valid_in = valid_ff[elig_idx];
            entry_dirty_in = 1'b0;
            entry_pins_in  = pins_ff[elig_idx];
            fidx_in        = elig_idx;
            wr_in          = 1'b1;
            wpage_in       = tpage_ff[elig_idx];
            last_in        = sts.flush_last;
         end
      end
   end

   // command latch, configuration and flush counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         flush_cnt_ff <= '0;
      end else begin
         if (csr_we) begin
            cfg_ff <= csr_data;
         end
         if (ctl.load) begin
            flush_cnt_ff <= '0;
         end else if (ctl.flush_step) begin
            flush_cnt_ff <= flush_cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff  <= req_command;
         page_ff <= req_page_number;
      end
   end

   // frame table state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FRAMES; i++) begin
            valid_ff[i] <= 1'b0;
            dirty_ff[i] <= 1'b0;
            pins_ff[i]  <= '0;
         end
      end else if (tbl_we) begin
         valid_ff[tbl_idx] <= entry_valid_in;
         dirty_ff[tbl_idx] <= entry_dirty_in;
         pins_ff[tbl_idx]  <= entry_pins_in;
      end
   end

   always_ff @(posedge clock) begin
      if (page_we) begin
         tpage_ff[tbl_idx] <= page_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= status_in;
      rsp_fidx_ff   <= FIDX_OUT_W'(fidx_in);
      rsp_rd_ff     <= rd_in;
      rsp_wr_ff     <= wr_in;
      rsp_wpage_ff  <= wpage_in;
      rsp_last_ff   <= last_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_frame_index   = rsp_fidx_ff;
   assign rsp_read_request  = rsp_rd_ff;
   assign rsp_write_request = rsp_wr_ff;
   assign rsp_write_page    = rsp_wpage_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

@@ src/buffer_pool_frame_table_core.sv @@
// ----------------------------------------------------------------------------
// buffer_pool_frame_table_core
// frame metadata table of a page buffer pool: pin, unpin, mark dirty, force
// and flush commands with read and write-back requests
// ----------------------------------------------------------------------------
//
// channel   ports                                   transfer when
// --------  --------------------------------------  -------------------------
// command   start, busy, req_command,               start high, busy low
//           req_page_number
// result    rsp_strobe, rsp_status, rsp_frame_index, rsp_strobe high (one
//           rsp_read_request, rsp_write_request,    cycle, cannot be held)
//           rsp_write_page, rsp_last
// config    csr_valid, csr_ready, csr_frames_in_use csr_valid and csr_ready
//
// pin, unpin, mark dirty, force and unknown codes run a single execute step;
//   the result strobes the cycle after, together with busy falling, and a
//   new command is taken only once busy is low
// flush all runs one step per cycle, one write-back transfer per dirty
//   unpinned frame (at most 16, or one empty result), busy until the last
//   step; the lowest eligible frame is picked each step from the table
// page match and victim search compare all frames in parallel
// reset clears the controller, valid, pin and dirty flags and sets the
//   frame count to 16; page numbers are only read from valid frames
// the result side has no back-pressure; config is always ready
//
module buffer_pool_frame_table_core #(
   parameter int FRAMES = bpft_pkg::FRAMES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // command channel
   input  logic                             start,
   output logic                             busy,
   input  logic [bpft_pkg::CMD_W-1:0]       req_command,
   input  logic [bpft_pkg::PAGE_BITS-1:0]   req_page_number,
   // result channel
   output logic                             rsp_strobe,
   output logic [bpft_pkg::STATUS_W-1:0]    rsp_status,
   output logic [bpft_pkg::FIDX_OUT_W-1:0]  rsp_frame_index,
   output logic                             rsp_read_request,
   output logic                             rsp_write_request,
   output logic [bpft_pkg::PAGE_BITS-1:0]   rsp_write_page,
   output logic                             rsp_last,
   // configuration channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bpft_pkg::CFG_W-1:0]       csr_frames_in_use
);
   import bpft_pkg::*;

   ctl_type ctl;
   sts_type sts;
   logic    busy_int;

   // register write needs no wait state
   assign csr_ready = 1'b1;

   // sequencer: one command at a time, start ignored while busy
   bpft_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .ctl   (ctl),
      .busy  (busy_int)
   );

   // table, match logic and result register
   bpft_datapath #(
      .FRAMES (FRAMES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .sts               (sts),
      .req_command       (req_command),
      .req_page_number   (req_page_number),
      .csr_we            (csr_valid && csr_ready),
      .csr_data          (csr_frames_in_use),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_read_request  (rsp_read_request),
      .rsp_write_request (rsp_write_request),
      .rsp_write_page    (rsp_write_page),
      .rsp_last          (rsp_last)
   );

   assign busy = busy_int;

   // a result only follows a working cycle
   a_rsp_after_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without a working cycle");

   // an accepted command always makes the block busy
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not start work");

   // error results close the command
   a_error_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != ST_OK)) |-> rsp_last)
      else $error("error result not marked last");

   // a read request comes only from a successful pin, as its single result
   a_read_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_read_request) |-> (rsp_status == ST_OK && rsp_last))
      else $error("read request on a failed or partial result");

   // busy is still high while a result that is not the last of its command is strobed
   a_last_idle : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> busy)
      else $error("block went idle before the final result");

endmodule
